[design/exponential_backoff_jitter_defines.svh]
// assertion macros shared by the backoff design files
`ifndef EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH
`define EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define EBJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define EBJ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EBJ_ASSERT(label, prop, msg)
`define EBJ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[design/ebj_pkg.sv]
// shared constants, types and tier tables for the backoff block
`default_nettype none

package ebj_pkg;

  localparam int SEED_W  = 64;
  localparam int ERR_W   = 16;
  localparam int DELAY_W = 17;
  localparam int TIER_W  = 3;
  localparam int SPAN_W  = 15;

  localparam logic [SEED_W-1:0] FALLBACK_SEED = 64'hBEEF_CAFE_1234_5678;
  localparam logic [TIER_W-1:0] MAX_TIER      = 3'd5;

  // request into the serial remainder unit
  typedef struct packed {
    logic              start;
    logic [SEED_W-1:0] dividend;
    logic [SPAN_W-1:0] divisor;
  } mod_req_t;

  // 80% of the base delay for a tier
  function automatic logic [DELAY_W-1:0] tier_floor(input logic [TIER_W-1:0] t);
    logic [DELAY_W-1:0] f;
    case (t)
      3'd0:    f = 17'd1600;
      3'd1:    f = 17'd3200;
      3'd2:    f = 17'd6400;
      3'd3:    f = 17'd12800;
      3'd4:    f = 17'd25600;
      default: f = 17'd48000;
    endcase
    return f;
  endfunction

  // 40% of the base delay for a tier
  function automatic logic [SPAN_W-1:0] tier_span(input logic [TIER_W-1:0] t);
    logic [SPAN_W-1:0] s;
    case (t)
      3'd0:    s = 15'd800;
      3'd1:    s = 15'd1600;
      3'd2:    s = 15'd3200;
      3'd3:    s = 15'd6400;
      3'd4:    s = 15'd12800;
      default: s = 15'd24000;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[design/ebj_rng.sv]
// xorshift64 generator state with seed load
`default_nettype none

module ebj_rng (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire logic [ebj_pkg::SEED_W-1:0] seed_value,
  input  wire logic                      advance,
  output logic      [ebj_pkg::SEED_W-1:0] state,
  output logic      [ebj_pkg::SEED_W-1:0] state_next
);
  import ebj_pkg::*;

  logic [SEED_W-1:0] x1;
  logic [SEED_W-1:0] x2;

  // one xorshift step, shifts 13, 7, 17
  always_comb begin
    x1         = state ^ (state << 13);
    x2         = x1 ^ (x1 >> 7);
    state_next = x2 ^ (x2 << 17);
  end

  // state register, zero seed replaced by the fallback
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FALLBACK_SEED;
    end else if (load) begin
      state <= (seed_value == '0) ? FALLBACK_SEED : seed_value;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[design/ebj_mod.sv]
// bit-serial restoring remainder of a 64-bit draw by a tier span
`default_nettype none

`include "exponential_backoff_jitter_defines.svh"

module ebj_mod (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ebj_pkg::mod_req_t         req,
  output logic                           done,
  output logic      [ebj_pkg::SPAN_W-1:0] rem
);
  import ebj_pkg::*;

  localparam int CNT_W = $clog2(SEED_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SEED_W-1:0] dividend;
  logic [SPAN_W-1:0] divisor;
  logic [SPAN_W:0]   trial;
  logic              fits;

  // shift in one dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dividend[SEED_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SEED_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      dividend <= dividend << 1;
      rem      <= fits ? SPAN_W'(trial - {1'b0, divisor}) : trial[SPAN_W-1:0];
    end
  end

  `EBJ_ASSERT(a_mod_rem_below_span, done |-> (rem < divisor), "remainder not below span")
  `EBJ_ASSERT(a_mod_no_restart, busy |-> !req.start, "remainder unit restarted while busy")
  `EBJ_ASSERT_ALWAYS(a_mod_done_pulse, done |=> !done, "done held longer than one cycle")

endmodule

`default_nettype wire

[design/exponential_backoff_jitter.sv]
// top level: exponential retry backoff with xorshift64 jitter
//
//  channel | direction | handshake             | word
//  in      | into      | in_valid / in_stall   | error_count
//  out     | out of    | out_valid / out_stall | delay_ms, tier
//  seed    | into      | seed_valid/seed_ready | seed
//
// the generator steps and the remainder unit starts at the accepting edge; the remainder
// is worked out bit by bit, then the floor is added as the output register loads, and the
// sequencer returns to idle with that load, so the next word can be taken from there on.
// rst is synchronous; it loads the generator with the fallback seed.
// a seed word is taken only while idle and holds off the input word in that cycle.
// a stalled output only holds off the next word once a second result is ready.
`default_nettype none

`include "exponential_backoff_jitter_defines.svh"

module exponential_backoff_jitter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [ebj_pkg::ERR_W-1:0] error_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [ebj_pkg::DELAY_W-1:0] delay_ms,
  output logic      [ebj_pkg::TIER_W-1:0]  tier,
  input  wire logic                        seed_valid,
  output logic                             seed_ready,
  input  wire logic [ebj_pkg::SEED_W-1:0]  seed
);
  import ebj_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state;
  logic [TIER_W-1:0] cur_tier;
  logic [TIER_W-1:0] tier_in;
  logic [ERR_W-2:0]  half;
  logic              accept;
  logic              seed_write;
  logic              out_free;
  logic              load_out;
  logic [SEED_W-1:0] rng_state;
  logic [SEED_W-1:0] rng_next;
  mod_req_t          mod_req;
  logic              mod_done;
  logic [SPAN_W-1:0] mod_rem;

  // handshakes, a seed write goes ahead of an input word
  assign in_stall   = (state != ST_IDLE) || seed_valid;
  assign seed_ready = (state == ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign seed_write = seed_valid && seed_ready;
  assign out_free   = !out_valid || !out_stall;
  assign load_out   = ((state == ST_RUN && mod_done) || state == ST_HOLD) && out_free;

  // tier from the error count, negatives as zero, capped
  always_comb begin
    half    = error_count[ERR_W-1] ? '0 : {1'b0, error_count[ERR_W-2:1]};
    tier_in = (half > (ERR_W-1)'(MAX_TIER)) ? MAX_TIER : half[TIER_W-1:0];
  end

  // generator
  ebj_rng u_rng (
    .clk        (clk),
    .rst        (rst),
    .load       (seed_write),
    .seed_value (seed),
    .advance    (accept),
    .state      (rng_state),
    .state_next (rng_next)
  );

  // draw goes straight into the remainder unit
  always_comb begin
    mod_req.start    = accept;
    mod_req.dividend = rng_next;
    mod_req.divisor  = tier_span(tier_in);
  end

  ebj_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_RUN;
        end
        ST_RUN: begin
          if (mod_done) state <= out_free ? ST_IDLE : ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // tier of the word in flight
  always_ff @(posedge clk) begin
    if (accept) cur_tier <= tier_in;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      delay_ms <= tier_floor(cur_tier) + DELAY_W'(mod_rem);
      tier     <= cur_tier;
    end
  end

  `EBJ_ASSERT(a_accept_then_busy, accept |=> in_stall, "not busy after accepting a word")
  `EBJ_ASSERT(a_out_in_range,
    out_valid |-> (tier <= MAX_TIER && delay_ms >= 17'd1600 && delay_ms <= 17'd71999),
    "result out of range")
  `EBJ_ASSERT(a_rng_steady,
    (!accept && !seed_write) |=> $stable(rng_state),
    "generator moved without a word or seed write")
  `EBJ_ASSERT(a_rng_nonzero, rng_state != '0, "generator state is zero")

endmodule

`default_nettype wire
